// ===== design/qvr_pkg.sv =====
package qvr_pkg;

  // quaternion parts are fixed at 16 bits
  localparam int QUAT_W  = 16;
  // product of two quaternion parts
  localparam int PROD_W  = 2 * QUAT_W;
  // sum or difference of two such products
  localparam int COEF_W  = PROD_W + 1;
  // row accumulator, wraps modulo 2^64
  localparam int ACC_W   = 64;
  localparam int OUT_W   = 18;
  // coef: 2 stages, mac: 3 stages, finish: 2 stages
  localparam int LATENCY = 7;

  // One matrix row without the factor 2 and without the identity term:
  // c0, c1, c2 multiply x, y, z.
  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } row_t;

  typedef struct packed {
    row_t r0;
    row_t r1;
    row_t r2;
  } coef_t;

endpackage

// ===== design/qvr_coef.sv =====
module qvr_coef (
  input  logic                               clk,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_r,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_j,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_k,
  output qvr_pkg::coef_t                     coef
);

  localparam int PW = qvr_pkg::PROD_W;
  localparam int CW = qvr_pkg::COEF_W;

  logic signed [PW-1:0] ii, jj, kk, ij, ik, jk, ir, jr, kr;

  // stage 1: the nine pairwise products
  always_ff @(posedge clk) begin
    ii <= PW'(quat_i) * PW'(quat_i);
    jj <= PW'(quat_j) * PW'(quat_j);
    kk <= PW'(quat_k) * PW'(quat_k);
    ij <= PW'(quat_i) * PW'(quat_j);
    ik <= PW'(quat_i) * PW'(quat_k);
    jk <= PW'(quat_j) * PW'(quat_k);
    ir <= PW'(quat_i) * PW'(quat_r);
    jr <= PW'(quat_j) * PW'(quat_r);
    kr <= PW'(quat_k) * PW'(quat_r);
  end

  // stage 2: matrix coefficients; the diagonal holds only -(a^2+b^2),
  // the identity term is added as a shift of the vector later
  always_ff @(posedge clk) begin
    coef.r0.c0 <= -CW'(jj) - CW'(kk);
    coef.r0.c1 <= CW'(ij) - CW'(kr);
    coef.r0.c2 <= CW'(ik) + CW'(jr);
    coef.r1.c0 <= CW'(ij) + CW'(kr);
    coef.r1.c1 <= -CW'(ii) - CW'(kk);
    coef.r1.c2 <= CW'(jk) - CW'(ir);
    coef.r2.c0 <= CW'(ik) - CW'(jr);
    coef.r2.c1 <= CW'(jk) + CW'(ir);
    coef.r2.c2 <= -CW'(ii) - CW'(jj);
  end

endmodule

// ===== design/qvr_mac.sv =====
module qvr_mac #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  qvr_pkg::row_t                      coef,
  input  logic signed [VEC_WIDTH-1:0]        vec_x,
  input  logic signed [VEC_WIDTH-1:0]        vec_y,
  input  logic signed [VEC_WIDTH-1:0]        vec_z,
  input  logic signed [VEC_WIDTH-1:0]        diag,
  output logic signed [qvr_pkg::ACC_W-1:0]   acc
);

  localparam int AW    = qvr_pkg::ACC_W;
  localparam int MUL_W = qvr_pkg::COEF_W + VEC_WIDTH;
  localparam int TWO_F = 2 * QUAT_FRAC_BITS;

  logic signed [MUL_W-1:0]     m0, m1, m2;
  logic signed [AW-1:0]        p0, p1, p2;
  logic signed [AW-1:0]        sum;
  logic signed [VEC_WIDTH-1:0] diag3, diag4;

  assign m0 = MUL_W'(coef.c0) * MUL_W'(vec_x);
  assign m1 = MUL_W'(coef.c1) * MUL_W'(vec_y);
  assign m2 = MUL_W'(coef.c2) * MUL_W'(vec_z);

  // stage 3: products, sign-extended to the accumulator width
  always_ff @(posedge clk) begin
    p0    <= AW'(m0);
    p1    <= AW'(m1);
    p2    <= AW'(m2);
    diag3 <= diag;
  end

  // stage 4: row sum of the off-identity part
  always_ff @(posedge clk) begin
    sum   <= p0 + p1 + p2;
    diag4 <= diag3;
  end

  // stage 5: apply the factor 2 and add the identity term
  always_ff @(posedge clk) begin
    acc <= (AW'(diag4) <<< TWO_F) + (sum <<< 1);
  end

endmodule

// ===== design/qvr_finish.sv =====
module qvr_finish #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [qvr_pkg::ACC_W-1:0]   acc,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot,
  output logic                               sat
);

  localparam int AW    = qvr_pkg::ACC_W;
  localparam int OW    = qvr_pkg::OUT_W;
  localparam int TWO_F = 2 * QUAT_FRAC_BITS;
  localparam logic [AW-1:0] POS_MAX = (AW'(1) << (OW - 1)) - AW'(1);
  localparam logic [AW-1:0] NEG_MAG = AW'(1) << (OW - 1);
  localparam logic signed [OW-1:0] RAIL_HI = OW'(POS_MAX);
  localparam logic signed [OW-1:0] RAIL_LO = OW'(NEG_MAG);

  logic          neg;
  logic [AW-1:0] mag;
  logic [AW-1:0] shifted;

  // stage 6: sign and magnitude, so the shift truncates toward zero
  always_ff @(posedge clk) begin
    neg <= acc[AW-1];
    mag <= acc[AW-1] ? $unsigned(-acc) : $unsigned(acc);
  end

  assign shifted = mag >> TWO_F;

  // stage 7: saturate and restore the sign
  always_ff @(posedge clk) begin
    if (!neg) begin
      if (shifted > POS_MAX) begin
        rot <= RAIL_HI;
        sat <= 1'b1;
      end else begin
        rot <= shifted[OW-1:0];
        sat <= 1'b0;
      end
    end else begin
      if (shifted > NEG_MAG) begin
        rot <= RAIL_LO;
        sat <= 1'b1;
      end else begin
        rot <= -shifted[OW-1:0];
        sat <= 1'b0;
      end
    end
  end

  a_sat_on_rail: assert property (@(posedge clk) disable iff (rst)
    sat |-> (rot == RAIL_HI || rot == RAIL_LO))
    else $error("clipped component is not at a rail");

endmodule

// ===== design/quaternion_vector_rotate.sv =====
// Rotates a signed vector by a quaternion in fixed point, one item per clock.
// An item is taken at every edge with start high (busy is never raised) and
// its result appears on rot_x/rot_y/rot_z/saturated with done high for a
// single cycle, after the register stages of the datapath (two for the
// matrix coefficients, three for the vector products and row sums, two
// for rounding and saturation). Results cannot be held off, so the receiver
// must take every one as it appears.
// The quaternion is used as given, without normalization; outputs truncate
// toward zero and clip to 18 bits, with saturated flagging any clip.
module quaternion_vector_rotate #(
  parameter int VEC_WIDTH      = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VEC_WIDTH-1:0]        vec_x,
  input  logic signed [VEC_WIDTH-1:0]        vec_y,
  input  logic signed [VEC_WIDTH-1:0]        vec_z,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_r,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_j,
  input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_k,
  output logic                               done,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_x,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_y,
  output logic signed [qvr_pkg::OUT_W-1:0]   rot_z,
  output logic                               saturated
);

  localparam int LAT = qvr_pkg::LATENCY;
  localparam int AW  = qvr_pkg::ACC_W;

  logic [LAT-1:0]              vld;
  logic signed [VEC_WIDTH-1:0] vx1, vy1, vz1, vx2, vy2, vz2;
  qvr_pkg::coef_t              coef;
  logic signed [AW-1:0]        acc_x, acc_y, acc_z;
  logic                        sat_x, sat_y, sat_z;

  assign busy = 1'b0;

  // valid bits travel alongside the datapath stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  // hold the vector until the coefficients are ready
  always_ff @(posedge clk) begin
    vx1 <= vec_x;
    vy1 <= vec_y;
    vz1 <= vec_z;
    vx2 <= vx1;
    vy2 <= vy1;
    vz2 <= vz1;
  end

  qvr_coef u_coef (
    .clk    (clk),
    .quat_r (quat_r),
    .quat_i (quat_i),
    .quat_j (quat_j),
    .quat_k (quat_k),
    .coef   (coef)
  );

  qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_mac_x (
    .clk(clk), .coef(coef.r0), .vec_x(vx2), .vec_y(vy2), .vec_z(vz2),
    .diag(vx2), .acc(acc_x)
  );

  qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_mac_y (
    .clk(clk), .coef(coef.r1), .vec_x(vx2), .vec_y(vy2), .vec_z(vz2),
    .diag(vy2), .acc(acc_y)
  );

  qvr_mac #(.VEC_WIDTH(VEC_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_mac_z (
    .clk(clk), .coef(coef.r2), .vec_x(vx2), .vec_y(vy2), .vec_z(vz2),
    .diag(vz2), .acc(acc_z)
  );

  qvr_finish #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_fin_x (
    .clk(clk), .rst(rst), .acc(acc_x), .rot(rot_x), .sat(sat_x)
  );

  qvr_finish #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_fin_y (
    .clk(clk), .rst(rst), .acc(acc_y), .rot(rot_y), .sat(sat_y)
  );

  qvr_finish #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_fin_z (
    .clk(clk), .rst(rst), .acc(acc_z), .rot(rot_z), .sat(sat_z)
  );

  assign done      = vld[LAT-1];
  assign saturated = sat_x | sat_y | sat_z;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && !busy && vec_x == '0 && vec_y == '0 && vec_z == '0, LAT)
    |-> (rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated))
    else $error("zero vector did not rotate to zero");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && !busy && quat_i == '0 && quat_j == '0 && quat_k == '0, LAT)
    |-> (saturated || rot_x == $past(vec_x, LAT)))
    else $error("pure real quaternion changed x");

endmodule

// ===== tb/quaternion_vector_rotate_tb.sv =====
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;

  localparam int VEC_W      = 16;
  localparam int FRAC_BITS  = 14;
  localparam int QW         = qvr_pkg::QUAT_W;
  localparam int OW         = qvr_pkg::OUT_W;
  localparam int STALL_MAX  = 2000;
  localparam int RAND_ITEMS = 450;

  typedef struct {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic signed [QW-1:0]    quat_r;
    logic signed [QW-1:0]    quat_i;
    logic signed [QW-1:0]    quat_j;
    logic signed [QW-1:0]    quat_k;
  } rot_item_t;

  typedef struct {
    logic signed [OW-1:0] rot_x;
    logic signed [OW-1:0] rot_y;
    logic signed [OW-1:0] rot_z;
    logic                 saturated;
  } rot_result_t;

  // shift a row sum toward zero and clip it; the top bit flags a clip
  function automatic logic [OW:0] clip_row(input longint acc);
    logic          neg;
    logic [63:0]   mag;
    logic [OW-1:0] val;
    neg = acc[63];
    mag = neg ? 64'(-acc) : 64'(acc);
    mag = mag >> (2 * FRAC_BITS);
    if (!neg) begin
      if (mag > 64'((1 << (OW - 1)) - 1)) return {1'b1, 1'b0, {(OW-1){1'b1}}};
      return {1'b0, mag[OW-1:0]};
    end
    if (mag > 64'(1 << (OW - 1))) return {1'b1, 1'b1, {(OW-1){1'b0}}};
    val = ~mag[OW-1:0] + OW'(1);
    return {1'b0, val};
  endfunction

  function automatic rot_result_t rotate_vec(input rot_item_t it);
    longint x, y, z, r, i, j, k, one;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic [OW:0] rx, ry, rz;
    rot_result_t res;
    x = longint'(it.vec_x);
    y = longint'(it.vec_y);
    z = longint'(it.vec_z);
    r = longint'(it.quat_r);
    i = longint'(it.quat_i);
    j = longint'(it.quat_j);
    k = longint'(it.quat_k);
    one = longint'(1) << (2 * FRAC_BITS);
    m00 = one - 2 * (j * j + k * k);
    m01 = 2 * (i * j - k * r);
    m02 = 2 * (i * k + j * r);
    m10 = 2 * (i * j + k * r);
    m11 = one - 2 * (i * i + k * k);
    m12 = 2 * (j * k - i * r);
    m20 = 2 * (i * k - j * r);
    m21 = 2 * (j * k + i * r);
    m22 = one - 2 * (i * i + j * j);
    rx = clip_row(m00 * x + m01 * y + m02 * z);
    ry = clip_row(m10 * x + m11 * y + m12 * z);
    rz = clip_row(m20 * x + m21 * y + m22 * z);
    res.rot_x = rx[OW-1:0];
    res.rot_y = ry[OW-1:0];
    res.rot_z = rz[OW-1:0];
    res.saturated = rx[OW] | ry[OW] | rz[OW];
    return res;
  endfunction

  class rotation_scoreboard;
    rot_result_t expected_rot[$];
    int          mismatches = 0;

    function void note_item(rot_item_t it);
      expected_rot.push_back(rotate_vec(it));
    endfunction

    function void check_result(rot_result_t got);
      rot_result_t want;
      if (expected_rot.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result x=%0d y=%0d z=%0d sat=%0b", $realtime,
                   got.rot_x, got.rot_y, got.rot_z, got.saturated);
        return;
      end
      want = expected_rot.pop_front();
      if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
          got.rot_z !== want.rot_z || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display(
            "%0t: mismatch expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
            $realtime, want.rot_x, want.rot_y, want.rot_z, want.saturated,
            got.rot_x, got.rot_y, got.rot_z, got.saturated);
      end
    endfunction

    function int pending();
      return expected_rot.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [VEC_W-1:0] vec_x, vec_y, vec_z;
  logic signed [QW-1:0]    quat_r, quat_i, quat_j, quat_k;
  logic                    done;
  logic signed [OW-1:0]    rot_x, rot_y, rot_z;
  logic                    saturated;

  rotation_scoreboard sb;
  int                 idle_cycles;

  quaternion_vector_rotate #(
    .VEC_WIDTH      (VEC_W),
    .QUAT_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .quat_r    (quat_r),
    .quat_i    (quat_i),
    .quat_j    (quat_j),
    .quat_k    (quat_k),
    .done      (done),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .saturated (saturated)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sample accepted items and results on the pre-edge values
  always @(posedge clk) begin
    rot_item_t   it;
    rot_result_t got;
    if (!rst) begin
      if (start && !busy) begin
        it.vec_x  = vec_x;
        it.vec_y  = vec_y;
        it.vec_z  = vec_z;
        it.quat_r = quat_r;
        it.quat_i = quat_i;
        it.quat_j = quat_j;
        it.quat_k = quat_k;
        sb.note_item(it);
      end
      if (done) begin
        got.rot_x     = rot_x;
        got.rot_y     = rot_y;
        got.rot_z     = rot_z;
        got.saturated = saturated;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic rot_item_t make_item(int x, int y, int z, int r, int i, int j, int k);
    rot_item_t it;
    it.vec_x  = VEC_W'(x);
    it.vec_y  = VEC_W'(y);
    it.vec_z  = VEC_W'(z);
    it.quat_r = QW'(r);
    it.quat_i = QW'(i);
    it.quat_j = QW'(j);
    it.quat_k = QW'(k);
    return it;
  endfunction

  function automatic rot_item_t make_random_item();
    rot_item_t it;
    int        sel, i, j, k, r;
    longint    rem;
    sel = int'($urandom_range(99));
    it.vec_x = VEC_W'($urandom());
    it.vec_y = VEC_W'($urandom());
    it.vec_z = VEC_W'($urandom());
    if (sel < 60) begin
      // near-unit quaternion: random i, j, k and r from the remaining norm
      i = int'($urandom_range(18918)) - 9459;
      j = int'($urandom_range(18918)) - 9459;
      k = int'($urandom_range(18918)) - 9459;
      rem = (longint'(1) << (2 * FRAC_BITS)) - longint'(i) * longint'(i)
            - longint'(j) * longint'(j) - longint'(k) * longint'(k);
      r = (rem > 0) ? int'($sqrt(real'(rem))) : 0;
      if ($urandom_range(1)) r = -r;
      it.quat_r = QW'(r);
      it.quat_i = QW'(i);
      it.quat_j = QW'(j);
      it.quat_k = QW'(k);
    end else if (sel < 85) begin
      it.quat_r = QW'($urandom());
      it.quat_i = QW'($urandom());
      it.quat_j = QW'($urandom());
      it.quat_k = QW'($urandom());
    end else begin
      it.quat_r = QW'(int'($urandom_range(32768)) - 16384);
      it.quat_i = QW'(int'($urandom_range(32768)) - 16384);
      it.quat_j = QW'(int'($urandom_range(32768)) - 16384);
      it.quat_k = QW'(int'($urandom_range(32768)) - 16384);
    end
    return it;
  endfunction

  // call at a rising edge; returns at the edge where the item is accepted
  task automatic send_item(input rot_item_t it, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    vec_x  <= it.vec_x;
    vec_y  <= it.vec_y;
    vec_z  <= it.vec_z;
    quat_r <= it.quat_r;
    quat_i <= it.quat_i;
    quat_j <= it.quat_j;
    quat_k <= it.quat_k;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_directed();
    // zero quaternion, with a zero vector and a nonzero one
    send_item(make_item(0, 0, 0, 0, 0, 0, 0), 0);
    send_item(make_item(32767, -32768, 1, 0, 0, 0, 0), 0);
    // identity, both signs of r
    send_item(make_item(32767, 32767, 32767, 16384, 0, 0, 0), 0);
    send_item(make_item(-32768, -32768, -32768, 16384, 0, 0, 0), 0);
    send_item(make_item(-32768, 32767, -1, -16384, 0, 0, 0), 0);
    // half turns about each axis
    send_item(make_item(1000, -2000, 3000, 0, 16384, 0, 0), 0);
    send_item(make_item(1000, -2000, 3000, 0, 0, 16384, 0), 0);
    send_item(make_item(1000, -2000, 3000, 0, 0, 0, 16384), 0);
    send_item(make_item(-32768, 32767, -32768, 0, -16384, 0, 0), 0);
    // quarter turns about each axis, then a turn about the x=y=z diagonal
    send_item(make_item(12345, -23456, 32767, 11585, 11585, 0, 0), 0);
    send_item(make_item(12345, -23456, 32767, 11585, 0, 11585, 0), 0);
    send_item(make_item(12345, -23456, 32767, 11585, 0, 0, -11585), 0);
    send_item(make_item(-1, -1, -1, 8192, 8192, 8192, 8192), 0);
    // non-unit and out-of-range quaternions, most of them driving saturation
    send_item(make_item(32767, 32767, 32767, -32768, -32768, -32768, -32768), 0);
    send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 0);
    send_item(make_item(32767, -32768, 32767, 32767, 32767, 32767, 32767), 0);
    send_item(make_item(-32768, 32767, -32768, 32767, -32768, 32767, -32768), 0);
    send_item(make_item(0, 32767, 0, 0, 32767, 0, 0), 0);
    send_item(make_item(0, -32768, 0, 0, 32767, 0, 0), 0);
    send_item(make_item(32767, 0, 0, 0, 0, 23170, 0), 0);
    send_item(make_item(500, 600, -700, 100, -200, 300, -400), 0);
    send_item(make_item(32767, 32767, 32767, 0, 0, 0, 0), 0);
  endtask

  initial begin
    int phase_idle[4];
    int p;
    int n;
    phase_idle = '{0, 54, 0, 27};
    sb = new();
    rst    = 1'b1;
    start  = 1'b0;
    vec_x  = '0;
    vec_y  = '0;
    vec_z  = '0;
    quat_r = '0;
    quat_i = '0;
    quat_j = '0;
    quat_k = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (p = 0; p < 4; p++) begin
      for (n = 0; n < RAND_ITEMS / 4; n++)
        send_item(make_random_item(), phase_idle[p]);
    end
    start <= 1'b0;
    // drain the pipeline, then watch for stray results
    while (sb.pending() > 0) @(posedge clk);
    repeat (qvr_pkg::LATENCY + 5) @(posedge clk);
    if (sb.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
